[design/shp_pkg.sv]
`timescale 1ns / 1ps

package shp_pkg;

    // Message constants
    localparam logic [7:0]  HS_SERVER_HELLO = 8'd2;
    localparam logic [15:0] EXT_SUP_VER     = 16'h002B;
    localparam logic [15:0] EXT_KEY_SHARE   = 16'h0033;
    localparam logic [15:0] RANDOM_LEN      = 16'd32;
    localparam logic [15:0] SV_LEN          = 16'd2;
    localparam logic [15:0] KEY_SHARE_MAX   = 16'd32;
    localparam logic [24:0] SEEN_MAX        = 25'h1FF_FFFF;

    // Output queue sizing (results per input word is at most two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result kinds
    localparam logic [1:0] KIND_RANDOM  = 2'd0;
    localparam logic [1:0] KIND_KEY     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Parse status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TYPE      = 3'd1;
    localparam logic [2:0] ST_LENGTH    = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_EXT_OVER  = 3'd4;
    localparam logic [2:0] ST_KEY_LONG  = 3'd5;
    localparam logic [2:0] ST_VER_LEN   = 3'd6;

    typedef enum logic [16:0] {
        PH_TYPE    = 17'b0_0000_0000_0000_0001,
        PH_LEN     = 17'b0_0000_0000_0000_0010,
        PH_VER     = 17'b0_0000_0000_0000_0100,
        PH_RAND    = 17'b0_0000_0000_0000_1000,
        PH_SIDLEN  = 17'b0_0000_0000_0001_0000,
        PH_SID     = 17'b0_0000_0000_0010_0000,
        PH_SUITE   = 17'b0_0000_0000_0100_0000,
        PH_COMP    = 17'b0_0000_0000_1000_0000,
        PH_EXTSLEN = 17'b0_0000_0001_0000_0000,
        PH_EXTHDR  = 17'b0_0000_0010_0000_0000,
        PH_SV      = 17'b0_0000_0100_0000_0000,
        PH_KSGRP   = 17'b0_0000_1000_0000_0000,
        PH_KSLEN   = 17'b0_0001_0000_0000_0000,
        PH_KSKEY   = 17'b0_0010_0000_0000_0000,
        PH_SKIP    = 17'b0_0100_0000_0000_0000,
        PH_DONE    = 17'b0_1000_0000_0000_0000,
        PH_ERR     = 17'b1_0000_0000_0000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  payload_byte;
        logic [4:0]  payload_index;
        logic [2:0]  parse_status;
        logic [15:0] legacy_ver;
        logic [7:0]  session_echo_len;
        logic [15:0] suite_code;
        logic [7:0]  compress_method;
        logic [15:0] chosen_version;
        logic [15:0] share_group;
        logic [5:0]  share_len;
    } t_result;

    // Results produced by one input word, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

[design/shp_byte_if.sv]
`timescale 1ns / 1ps

interface shp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       is_last;

    modport source (output valid, output msg_byte, output is_last, input ready);
    modport sink   (input valid, input msg_byte, input is_last, output ready);
endinterface

[design/shp_result_if.sv]
`timescale 1ns / 1ps

interface shp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  payload_byte;
    logic [4:0]  payload_index;
    logic [2:0]  parse_status;
    logic [15:0] legacy_ver;
    logic [7:0]  session_echo_len;
    logic [15:0] suite_code;
    logic [7:0]  compress_method;
    logic [15:0] chosen_version;
    logic [15:0] share_group;
    logic [5:0]  share_len;

    modport source (
        output valid, output out_kind, output payload_byte, output payload_index,
        output parse_status, output legacy_ver, output session_echo_len,
        output suite_code, output compress_method, output chosen_version,
        output share_group, output share_len, input ready
    );
    modport sink (
        input valid, input out_kind, input payload_byte, input payload_index,
        input parse_status, input legacy_ver, input session_echo_len,
        input suite_code, input compress_method, input chosen_version,
        input share_group, input share_len, output ready
    );
endinterface

[design/shp_core.sv]
`timescale 1ns / 1ps

module shp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_msg_byte,
    input  logic           i_is_last,
    output shp_pkg::t_push o_push
);
    import shp_pkg::*;

    t_phase      r_phase,      n_phase;
    logic [15:0] r_fbl,        n_fbl;
    logic [24:0] r_seen,       n_seen;
    logic [23:0] r_hs_len,     n_hs_len;
    logic [24:0] r_ext_end,    n_ext_end;
    logic [15:0] r_cur_type,   n_cur_type;
    logic [15:0] r_cur_left,   n_cur_left;
    logic [23:0] r_asm,        n_asm;
    logic [15:0] r_cap_ver,    n_cap_ver;
    logic [7:0]  r_cap_echo,   n_cap_echo;
    logic [15:0] r_cap_suite,  n_cap_suite;
    logic [7:0]  r_cap_comp,   n_cap_comp;
    logic [15:0] r_cap_chosen, n_cap_chosen;
    logic [15:0] r_cap_group,  n_cap_group;
    logic [5:0]  r_cap_slen,   n_cap_slen;
    logic [2:0]  r_err,        n_err;

    always_comb begin
        logic [25:0] nxt;
        logic [23:0] asm_acc;
        logic [15:0] fbl_dec;
        logic [15:0] fld;
        logic [26:0] sum;
        logic [15:0] klen;
        logic [15:0] cur_dec;
        logic        err_set;
        logic [2:0]  err_val;
        logic        ext_done;
        logic        pay_valid;
        t_result     pay;
        t_result     summ;
        logic [2:0]  st;

        n_phase      = r_phase;
        n_fbl        = r_fbl;
        n_hs_len     = r_hs_len;
        n_ext_end    = r_ext_end;
        n_cur_type   = r_cur_type;
        n_cur_left   = r_cur_left;
        n_asm        = r_asm;
        n_cap_ver    = r_cap_ver;
        n_cap_echo   = r_cap_echo;
        n_cap_suite  = r_cap_suite;
        n_cap_comp   = r_cap_comp;
        n_cap_chosen = r_cap_chosen;
        n_cap_group  = r_cap_group;
        n_cap_slen   = r_cap_slen;
        n_err        = r_err;

        nxt       = {1'b0, r_seen} + 26'd1;
        n_seen    = (r_seen != SEEN_MAX) ? r_seen + 25'd1 : r_seen;
        asm_acc   = {r_asm[15:0], i_msg_byte};
        fbl_dec   = r_fbl - 16'd1;
        cur_dec   = r_cur_left - 16'd1;
        klen      = r_cur_left - 16'd4;
        fld       = asm_acc[15:0];
        sum       = '0;
        err_set   = 1'b0;
        err_val   = ST_OK;
        ext_done  = 1'b0;
        pay_valid = 1'b0;
        pay       = '0;

        unique case (r_phase)
            PH_TYPE: begin
                if (i_msg_byte != HS_SERVER_HELLO) begin
                    err_set = 1'b1;
                    err_val = ST_TYPE;
                end else begin
                    n_phase = PH_LEN;
                    n_fbl   = 16'd3;
                    n_asm   = '0;
                end
            end
            PH_LEN: begin
                n_asm = asm_acc;
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    n_hs_len = asm_acc;
                    n_phase  = PH_VER;
                    n_fbl    = 16'd2;
                    n_asm    = '0;
                end
            end
            PH_VER: begin
                n_asm = asm_acc;
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    n_cap_ver = fld;
                    n_phase   = PH_RAND;
                    n_fbl     = RANDOM_LEN;
                end
            end
            PH_RAND: begin
                pay_valid         = 1'b1;
                pay.out_kind      = KIND_RANDOM;
                pay.payload_byte  = i_msg_byte;
                pay.payload_index = 5'(RANDOM_LEN - r_fbl);
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    n_phase = PH_SIDLEN;
                end
            end
            PH_SIDLEN: begin
                n_cap_echo = i_msg_byte;
                n_asm      = '0;
                if (i_msg_byte == 8'd0) begin
                    n_fbl   = 16'd2;
                    n_phase = PH_SUITE;
                end else begin
                    n_fbl   = {8'd0, i_msg_byte};
                    n_phase = PH_SID;
                end
            end
            PH_SID: begin
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    n_phase = PH_SUITE;
                    n_fbl   = 16'd2;
                    n_asm   = '0;
                end
            end
            PH_SUITE: begin
                n_asm = asm_acc;
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    n_cap_suite = fld;
                    n_phase     = PH_COMP;
                end
            end
            PH_COMP: begin
                n_cap_comp = i_msg_byte;
                n_phase    = PH_EXTSLEN;
                n_fbl      = 16'd2;
                n_asm      = '0;
            end
            PH_EXTSLEN: begin
                n_asm = asm_acc;
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    sum       = {1'b0, nxt} + {11'd0, fld};
                    n_ext_end = sum[24:0];
                    if (sum > {3'd0, r_hs_len} + 27'd4) begin
                        err_set = 1'b1;
                        err_val = ST_EXT_OVER;
                    end else begin
                        ext_done = 1'b1;
                    end
                end
            end
            PH_EXTHDR: begin
                if (r_seen >= r_ext_end) begin
                    err_set = 1'b1;
                    err_val = ST_EXT_OVER;
                end else begin
                    n_asm = asm_acc;
                    n_fbl = fbl_dec;
                    if (fbl_dec == 16'd2) begin
                        n_cur_type = fld;
                        n_asm      = '0;
                    end else if (fbl_dec == 16'd0) begin
                        n_asm = '0;
                        sum   = {1'b0, nxt} + {11'd0, fld};
                        if (sum > {2'd0, r_ext_end}) begin
                            err_set = 1'b1;
                            err_val = ST_EXT_OVER;
                        end else begin
                            n_cur_left = fld;
                            if (r_cur_type == EXT_SUP_VER) begin
                                if (fld != SV_LEN) begin
                                    err_set = 1'b1;
                                    err_val = ST_VER_LEN;
                                end else begin
                                    n_phase = PH_SV;
                                    n_fbl   = 16'd2;
                                end
                            end else if (r_cur_type == EXT_KEY_SHARE) begin
                                if (fld < 16'd4) begin
                                    err_set = 1'b1;
                                    err_val = ST_EXT_OVER;
                                end else begin
                                    n_phase = PH_KSGRP;
                                    n_fbl   = 16'd2;
                                end
                            end else if (fld == 16'd0) begin
                                ext_done = 1'b1;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                end
            end
            PH_SV: begin
                n_asm = asm_acc;
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    n_cap_chosen = fld;
                    ext_done     = 1'b1;
                end
            end
            PH_KSGRP: begin
                n_asm = asm_acc;
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    n_phase = PH_KSLEN;
                    n_fbl   = 16'd2;
                end
            end
            PH_KSLEN: begin
                if (r_fbl == 16'd2) begin
                    n_asm = asm_acc;
                    n_fbl = 16'd1;
                end else begin
                    // key length is the byte held in the low bits of r_asm followed by this byte
                    klen = {r_asm[7:0], i_msg_byte};
                    if (klen > KEY_SHARE_MAX) begin
                        err_set = 1'b1;
                        err_val = ST_KEY_LONG;
                    end else if ({1'b0, klen} + 17'd4 != {1'b0, r_cur_left}) begin
                        err_set = 1'b1;
                        err_val = ST_EXT_OVER;
                    end else if (klen == 16'd0) begin
                        n_cap_group = r_asm[23:8];
                        n_cap_slen  = '0;
                        ext_done    = 1'b1;
                    end else begin
                        n_asm   = {8'd0, r_asm[23:8]};
                        n_fbl   = klen;
                        n_phase = PH_KSKEY;
                    end
                end
            end
            PH_KSKEY: begin
                pay_valid         = 1'b1;
                pay.out_kind      = KIND_KEY;
                pay.payload_byte  = i_msg_byte;
                pay.payload_index = 5'(klen - r_fbl);
                n_fbl = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    n_cap_group = r_asm[15:0];
                    n_cap_slen  = (klen > 16'd63) ? 6'd63 : klen[5:0];
                    ext_done    = 1'b1;
                end
            end
            PH_SKIP: begin
                n_cur_left = cur_dec;
                if (cur_dec == 16'd0) begin
                    ext_done = 1'b1;
                end
            end
            PH_DONE, PH_ERR: begin
                // trailing bytes, or parsing stopped on an error
            end
            default: begin
            end
        endcase

        if (err_set) begin
            if (r_err == ST_OK) begin
                n_err = err_val;
            end
            n_phase = PH_ERR;
        end

        // Extension finished: next header or end of the block
        if (ext_done) begin
            if (nxt >= {1'b0, n_ext_end}) begin
                n_phase = PH_DONE;
            end else begin
                n_phase = PH_EXTHDR;
                n_fbl   = 16'd4;
                n_asm   = '0;
            end
        end

        if (n_err == ST_TYPE) begin
            st = ST_TYPE;
        end else if (n_phase == PH_TYPE || n_phase == PH_LEN) begin
            st = ST_TRUNC;
        end else if (n_seen != {1'b0, n_hs_len} + 25'd4) begin
            st = ST_LENGTH;
        end else if (n_err != ST_OK) begin
            st = n_err;
        end else if (n_phase != PH_DONE) begin
            st = ST_TRUNC;
        end else begin
            st = ST_OK;
        end

        summ                  = '0;
        summ.out_kind         = KIND_SUMMARY;
        summ.parse_status     = st;
        summ.legacy_ver       = n_cap_ver;
        summ.session_echo_len = n_cap_echo;
        summ.suite_code       = n_cap_suite;
        summ.compress_method  = n_cap_comp;
        summ.chosen_version   = n_cap_chosen;
        summ.share_group      = n_cap_group;
        summ.share_len        = n_cap_slen;

        o_push = '0;
        if (pay_valid) begin
            o_push.first  = pay;
            o_push.second = summ;
            o_push.cnt    = i_is_last ? 2'd2 : 2'd1;
        end else begin
            o_push.first  = summ;
            o_push.cnt    = i_is_last ? 2'd1 : 2'd0;
        end
        if (!i_accept) begin
            o_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        // The last word of a message returns everything to the reset state
        if (!i_rst_n || (i_accept && i_is_last)) begin
            r_phase      <= PH_TYPE;
            r_fbl        <= '0;
            r_seen       <= '0;
            r_hs_len     <= '0;
            r_ext_end    <= '0;
            r_cur_type   <= '0;
            r_cur_left   <= '0;
            r_asm        <= '0;
            r_cap_ver    <= '0;
            r_cap_echo   <= '0;
            r_cap_suite  <= '0;
            r_cap_comp   <= '0;
            r_cap_chosen <= '0;
            r_cap_group  <= '0;
            r_cap_slen   <= '0;
            r_err        <= ST_OK;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_fbl        <= n_fbl;
            r_seen       <= n_seen;
            r_hs_len     <= n_hs_len;
            r_ext_end    <= n_ext_end;
            r_cur_type   <= n_cur_type;
            r_cur_left   <= n_cur_left;
            r_asm        <= n_asm;
            r_cap_ver    <= n_cap_ver;
            r_cap_echo   <= n_cap_echo;
            r_cap_suite  <= n_cap_suite;
            r_cap_comp   <= n_cap_comp;
            r_cap_chosen <= n_cap_chosen;
            r_cap_group  <= n_cap_group;
            r_cap_slen   <= n_cap_slen;
            r_err        <= n_err;
        end
    end

endmodule

[design/shp_out_queue.sv]
`timescale 1ns / 1ps

module shp_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  shp_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output shp_pkg::t_result o_head
);
    import shp_pkg::*;

    t_result             r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;
    logic                pop;
    logic [QPTR_W-1:0]   wr_ptr_p1;

    // Room for a full pair of results from the next word
    assign o_room    = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_valid   = (r_count != '0);
    assign o_head    = r_entry[r_rd_ptr];
    assign pop       = o_valid && i_ready;
    assign wr_ptr_p1 = r_wr_ptr + QPTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push.cnt);
        n_rd_ptr = pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_entry[wr_ptr_p1] <= i_push.second;
        end
    end

endmodule

[design/server_hello_stream_parser.sv]
`timescale 1ns / 1ps

// ServerHello stream parser.
// i_in (sink): one message byte per word, is_last set on the final byte.
// o_out (source): result words. A random byte (kind 0) or key share byte
//   (kind 1) comes out for each such byte of the message; the final byte
//   also yields a summary word (kind 2) with the status and captured fields.
// Output: a word accepted at an edge has its first result at o_out right
//   after that edge. A byte that makes two results puts both in the
//   output queue at once; they leave in order as the receiver takes them.
// Throughput: one byte per cycle while the output queue has room. The field
//   state machine takes each accepted byte with no busy state; ready is set by
//   the four-word output queue only, which must have room for two words.
// Reset: synchronous, active low; parser back to expecting the type byte,
//   queue emptied. After each final byte the parser also returns to that state.
// Receiver stall: results wait in the queue; once it holds three or more
//   words, i_in.ready drops until words are taken.
module server_hello_stream_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    shp_byte_if.sink     i_in,
    shp_result_if.source o_out
);
    import shp_pkg::*;

    t_push   push;
    t_result head;
    logic    room;
    logic    accept;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    // Field state machine: one byte in, up to two results out
    shp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_msg_byte (i_in.msg_byte),
        .i_is_last  (i_in.is_last),
        .o_push     (push)
    );

    // Result queue decouples the parser from a stalling receiver
    shp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_head  (head)
    );

    assign o_out.out_kind         = head.out_kind;
    assign o_out.payload_byte     = head.payload_byte;
    assign o_out.payload_index    = head.payload_index;
    assign o_out.parse_status     = head.parse_status;
    assign o_out.legacy_ver       = head.legacy_ver;
    assign o_out.session_echo_len = head.session_echo_len;
    assign o_out.suite_code       = head.suite_code;
    assign o_out.compress_method  = head.compress_method;
    assign o_out.chosen_version   = head.chosen_version;
    assign o_out.share_group      = head.share_group;
    assign o_out.share_len        = head.share_len;

endmodule
